/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// implication checks used across the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, ck, rn, ante, cons)
`define ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

/* hw/rtl/lia_pkg.sv */
// ----------------------------------------------------------------------------
// lia_pkg
// types and widths shared by the line intersection block
// ----------------------------------------------------------------------------
package lia_pkg;

	localparam int COORD_BITS = 32;
	// line coefficients a, b
	localparam int AW = COORD_BITS + 1;
	// line constant c = a*x + b*y
	localparam int CW = 2 * COORD_BITS + 2;
	// determinant
	localparam int DETW = 2 * COORD_BITS + 3;
	// cramer numerators
	localparam int NUMW = 3 * COORD_BITS + 4;
	// rounded dividend 2|n| + |d| and divisor 2|d|
	localparam int NW = NUMW + 2;
	localparam int DW = DETW + 1;
	// split of c for the partial products
	localparam int CHW = CW - AW;
	localparam int PLW = 2 * AW + 1;
	localparam int PHW = AW + CHW;
	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTRW = $clog2(QDEPTH);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_start_x;
		logic signed [COORD_BITS-1:0] first_start_y;
		logic signed [COORD_BITS-1:0] first_end_x;
		logic signed [COORD_BITS-1:0] first_end_y;
		logic signed [COORD_BITS-1:0] second_start_x;
		logic signed [COORD_BITS-1:0] second_start_y;
		logic signed [COORD_BITS-1:0] second_end_x;
		logic signed [COORD_BITS-1:0] second_end_y;
	} seg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cross_x;
		logic signed [COORD_BITS-1:0] cross_y;
		logic                         is_parallel;
		logic                         did_saturate;
	} isect_t;

	// classified pair of lines as queued for the solver
	typedef struct packed {
		logic signed [AW-1:0]   a1;
		logic signed [AW-1:0]   b1;
		logic signed [AW-1:0]   a2;
		logic signed [AW-1:0]   b2;
		logic signed [CW-1:0]   c1;
		logic signed [CW-1:0]   c2;
		logic signed [DETW-1:0] det;
	} line_t;

endpackage

/* hw/rtl/lia_front.sv */
// ----------------------------------------------------------------------------
// lia_front
// forms a, b, c of both lines and the determinant, pushes them to the queue
// ----------------------------------------------------------------------------
module lia_front import lia_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  seg_valid,
	output logic  seg_ready,
	input  seg_t  seg,
	output logic  push,
	output line_t entry,
	input  logic  q_full
);

	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [COORD_BITS-1:0] x1_s1, y1_s1, x2_s1, y2_s1;

	logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [AW+COORD_BITS-1:0] a1x1_s2, b1y1_s2, a2x2_s2, b2y2_s2;
	logic signed [2*AW-1:0] a1b2_s2, a2b1_s2;

	line_t e_s3;

	assign en = !(v_s3 && q_full);
	assign seg_ready = en;
	assign push = v_s3 && en;
	assign entry = e_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// line coefficients
			a1_s1 <= AW'(seg.first_end_y) - AW'(seg.first_start_y);
			b1_s1 <= AW'(seg.first_start_x) - AW'(seg.first_end_x);
			a2_s1 <= AW'(seg.second_end_y) - AW'(seg.second_start_y);
			b2_s1 <= AW'(seg.second_start_x) - AW'(seg.second_end_x);
			x1_s1 <= seg.first_start_x;
			y1_s1 <= seg.first_start_y;
			x2_s1 <= seg.second_start_x;
			y2_s1 <= seg.second_start_y;
			// products
			a1_s2   <= a1_s1;
			b1_s2   <= b1_s1;
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			a1x1_s2 <= a1_s1 * x1_s1;
			b1y1_s2 <= b1_s1 * y1_s1;
			a2x2_s2 <= a2_s1 * x2_s1;
			b2y2_s2 <= b2_s1 * y2_s1;
			a1b2_s2 <= a1_s1 * b2_s1;
			a2b1_s2 <= a2_s1 * b1_s1;
			// sums
			e_s3.a1  <= a1_s2;
			e_s3.b1  <= b1_s2;
			e_s3.a2  <= a2_s2;
			e_s3.b2  <= b2_s2;
			e_s3.c1  <= CW'(a1x1_s2) + CW'(b1y1_s2);
			e_s3.c2  <= CW'(a2x2_s2) + CW'(b2y2_s2);
			e_s3.det <= DETW'(a1b2_s2) - DETW'(a2b1_s2);
		end
	end

endmodule

/* hw/rtl/lia_queue.sv */
// ----------------------------------------------------------------------------
// lia_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lia_queue import lia_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  line_t wr_entry,
	output logic  full,
	input  logic  pop,
	output line_t rd_entry,
	output logic  empty
);

	line_t mem_q [QDEPTH];
	logic [QPTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTRW:0]   cnt_q;

	assign full = cnt_q == (QPTRW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full)
	`ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty)
	`ASSERT_NXT(a_cnt_hold, clk, arst_n, !push && !pop, $stable(cnt_q))

endmodule

/* hw/rtl/lia_div.sv */
// ----------------------------------------------------------------------------
// lia_div
// pipelined restoring divider, one quotient bit per stage, with range check
// ----------------------------------------------------------------------------
module lia_div import lia_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [NW-1:0]         num,
	input  logic [DW-1:0]         den,
	input  logic                  neg_in,
	output logic [COORD_BITS-1:0] quo,
	output logic                  ovf,
	output logic                  neg
);

	logic [NW-1:0]         r_q   [0:COORD_BITS];
	logic [DW-1:0]         d_q   [0:COORD_BITS];
	logic [COORD_BITS-1:0] qq_q  [0:COORD_BITS];
	logic                  ovf_q [0:COORD_BITS];
	logic                  neg_q [0:COORD_BITS];

	// a quotient of more than COORD_BITS bits is out of range anyway
	always_ff @(posedge clk) begin
		if (en) begin
			r_q[0]   <= num;
			d_q[0]   <= den;
			qq_q[0]  <= '0;
			ovf_q[0] <= num >= (NW'(den) << COORD_BITS);
			neg_q[0] <= neg_in;
		end
	end

	for (genvar k = 0; k < COORD_BITS; k++) begin : g_stage
		localparam int SH = COORD_BITS - 1 - k;
		logic [NW-1:0] dsh;
		logic          ge;

		assign dsh = NW'(d_q[k]) << SH;
		assign ge = r_q[k] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k+1]   <= ge ? r_q[k] - dsh : r_q[k];
				d_q[k+1]   <= d_q[k];
				qq_q[k+1]  <= {qq_q[k][COORD_BITS-2:0], ge};
				ovf_q[k+1] <= ovf_q[k];
				neg_q[k+1] <= neg_q[k];
			end
		end
	end

	assign quo = qq_q[COORD_BITS];
	assign ovf = ovf_q[COORD_BITS];
	assign neg = neg_q[COORD_BITS];

endmodule

/* hw/rtl/lia_back.sv */
// ----------------------------------------------------------------------------
// lia_back
// cramer numerators, rounding, two dividers, saturation and output register
// ----------------------------------------------------------------------------
module lia_back import lia_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  line_t  q_entry,
	input  logic   q_empty,
	output logic   pop,
	output logic   isect_valid,
	input  logic   isect_ready,
	output isect_t isect
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_out_q;
	logic v_d_q   [0:COORD_BITS];
	logic par_d_q [0:COORD_BITS];

	// partial products of b2*c1, b1*c2, a1*c2, a2*c1
	logic signed [PLW-1:0] l_b2c1_s1, l_b1c2_s1, l_a1c2_s1, l_a2c1_s1;
	logic signed [PHW-1:0] h_b2c1_s1, h_b1c2_s1, h_a1c2_s1, h_a2c1_s1;
	logic signed [DETW-1:0] det_s1, det_s2, det_s3;
	logic signed [NUMW-1:0] b2c1_s2, b1c2_s2, a1c2_s2, a2c1_s2;
	logic signed [NUMW-1:0] nx_s3, ny_s3;
	logic [NUMW-1:0] mx_s4, my_s4;
	logic [DETW-1:0] md_s4;
	logic nx_neg_s4, ny_neg_s4, d_neg_s4, par_s4;
	logic [NW-1:0] numx_s5, numy_s5;
	logic [DW-1:0] den_s5;
	logic xneg_s5, yneg_s5, par_s5;

	logic [COORD_BITS-1:0] qx, qy;
	logic ovfx, ovfy, negx, negy;
	logic [COORD_BITS:0] rx, ry;
	isect_t isect_q;

	function automatic logic [COORD_BITS:0] clamp(
		input logic [COORD_BITS-1:0] q,
		input logic                  ovf,
		input logic                  ng
	);
		logic [COORD_BITS-1:0] lim;
		logic [COORD_BITS-1:0] v;
		logic                  s;
		lim = ng ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
		s = ovf || (q > lim);
		v = s ? lim : q;
		v = ng ? COORD_BITS'(~v + 1'b1) : v;
		return {s, v};
	endfunction

	assign en = !v_out_q || isect_ready;
	assign pop = en && !q_empty;
	assign isect_valid = v_out_q;
	assign isect = isect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_out_q <= 1'b0;
			for (int i = 0; i <= COORD_BITS; i++) begin
				v_d_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_d_q[0] <= v_s5;
			for (int i = 1; i <= COORD_BITS; i++) begin
				v_d_q[i] <= v_d_q[i-1];
			end
			v_out_q <= v_d_q[COORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// split c into signed high and unsigned low halves
			l_b2c1_s1 <= q_entry.b2 * $signed({1'b0, q_entry.c1[AW-1:0]});
			h_b2c1_s1 <= q_entry.b2 * $signed(q_entry.c1[CW-1:AW]);
			l_b1c2_s1 <= q_entry.b1 * $signed({1'b0, q_entry.c2[AW-1:0]});
			h_b1c2_s1 <= q_entry.b1 * $signed(q_entry.c2[CW-1:AW]);
			l_a1c2_s1 <= q_entry.a1 * $signed({1'b0, q_entry.c2[AW-1:0]});
			h_a1c2_s1 <= q_entry.a1 * $signed(q_entry.c2[CW-1:AW]);
			l_a2c1_s1 <= q_entry.a2 * $signed({1'b0, q_entry.c1[AW-1:0]});
			h_a2c1_s1 <= q_entry.a2 * $signed(q_entry.c1[CW-1:AW]);
			det_s1 <= q_entry.det;
			// recombine
			b2c1_s2 <= (NUMW'(h_b2c1_s1) <<< AW) + NUMW'(l_b2c1_s1);
			b1c2_s2 <= (NUMW'(h_b1c2_s1) <<< AW) + NUMW'(l_b1c2_s1);
			a1c2_s2 <= (NUMW'(h_a1c2_s1) <<< AW) + NUMW'(l_a1c2_s1);
			a2c1_s2 <= (NUMW'(h_a2c1_s1) <<< AW) + NUMW'(l_a2c1_s1);
			det_s2 <= det_s1;
			// numerators
			nx_s3 <= b2c1_s2 - b1c2_s2;
			ny_s3 <= a1c2_s2 - a2c1_s2;
			det_s3 <= det_s2;
			// sign and magnitude
			nx_neg_s4 <= nx_s3[NUMW-1];
			ny_neg_s4 <= ny_s3[NUMW-1];
			d_neg_s4 <= det_s3[DETW-1];
			mx_s4 <= nx_s3[NUMW-1] ? NUMW'(-nx_s3) : NUMW'(nx_s3);
			my_s4 <= ny_s3[NUMW-1] ? NUMW'(-ny_s3) : NUMW'(ny_s3);
			md_s4 <= det_s3[DETW-1] ? DETW'(-det_s3) : DETW'(det_s3);
			par_s4 <= det_s3 == '0;
			// round to nearest: (2n + d) / 2d
			numx_s5 <= NW'({mx_s4, 1'b0}) + NW'(md_s4);
			numy_s5 <= NW'({my_s4, 1'b0}) + NW'(md_s4);
			den_s5 <= {md_s4, 1'b0};
			xneg_s5 <= nx_neg_s4 ^ d_neg_s4;
			yneg_s5 <= ny_neg_s4 ^ d_neg_s4;
			par_s5 <= par_s4;
			// parallel flag rides along with the dividers
			par_d_q[0] <= par_s5;
			for (int i = 1; i <= COORD_BITS; i++) begin
				par_d_q[i] <= par_d_q[i-1];
			end
			// output register
			isect_q.is_parallel <= par_d_q[COORD_BITS];
			isect_q.did_saturate <= !par_d_q[COORD_BITS] && (rx[COORD_BITS] || ry[COORD_BITS]);
			isect_q.cross_x <= par_d_q[COORD_BITS] ? '0 : $signed(rx[COORD_BITS-1:0]);
			isect_q.cross_y <= par_d_q[COORD_BITS] ? '0 : $signed(ry[COORD_BITS-1:0]);
		end
	end

	lia_div u_div_x (
		.clk    (clk),
		.en     (en),
		.num    (numx_s5),
		.den    (den_s5),
		.neg_in (xneg_s5),
		.quo    (qx),
		.ovf    (ovfx),
		.neg    (negx)
	);

	lia_div u_div_y (
		.clk    (clk),
		.en     (en),
		.num    (numy_s5),
		.den    (den_s5),
		.neg_in (yneg_s5),
		.quo    (qy),
		.ovf    (ovfy),
		.neg    (negy)
	);

	assign rx = clamp(qx, ovfx, negx);
	assign ry = clamp(qy, ovfy, negy);

endmodule

/* hw/rtl/line_intersection_2d.sv */
// ----------------------------------------------------------------------------
// line_intersection_2d
// intersection of two infinite lines in signed q16.16, cramer's rule
// ----------------------------------------------------------------------------
// Takes one pair of segments per item and returns one result item per pair,
// in order. Each segment defines the line a*x + b*y = c; the point is solved
// exactly with rounding to nearest (ties away from zero). A zero determinant
// sets is_parallel with zero coordinates; a coordinate out of range clamps and
// sets did_saturate. One item per clock is sustained when the output is taken
// every cycle. From input accept to result valid with an idle queue, the item
// passes 3 front stages (coefficients, products, sums), one queue slot,
// 5 back stages (split products, recombine, numerators, magnitude, rounding),
// 33 divider stages (range check then one quotient bit per stage), and the
// output register, the first of which is loaded at the accepting edge. The
// depth is set by the restoring dividers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_intersection_2d import lia_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   seg_valid,
	output logic   seg_ready,
	input  seg_t   seg,
	output logic   isect_valid,
	input  logic   isect_ready,
	output isect_t isect
);

	// front to queue
	logic  push;
	logic  q_full;
	line_t wr_entry;
	// queue to back
	logic  pop;
	logic  q_empty;
	line_t rd_entry;

	// front: line coefficients and determinant
	lia_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg       (seg),
		.push      (push),
		.entry     (wr_entry),
		.q_full    (q_full)
	);

	// decouples the two halves so each stalls on its own
	lia_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (pop),
		.rd_entry (rd_entry),
		.empty    (q_empty)
	);

	// back: numerators, division, clamping
	lia_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_entry     (rd_entry),
		.q_empty     (q_empty),
		.pop         (pop),
		.isect_valid (isect_valid),
		.isect_ready (isect_ready),
		.isect       (isect)
	);

	// a parallel result carries zero coordinates and no saturation
	`ASSERT_IMP(a_par_zero, clk, arst_n, isect_valid && isect.is_parallel, isect.cross_x == '0 && isect.cross_y == '0 && !isect.did_saturate)

endmodule
